/* design/apra_pkg.sv */
// shared types and constants for the arithmetic progression range add block
package apra_pkg;

   localparam int MAX_LENGTH_DEF = 1024;
   localparam int LEN_W          = 11;
   localparam int WORD_W         = 64;

   localparam logic [LEN_W-1:0] LENGTH_RESET = 11'd1024;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // one fenwick node: coefficient of the position and constant part
   typedef struct packed {
      logic [WORD_W-1:0] slope;
      logic [WORD_W-1:0] base;
   } node_type;

endpackage

/* design/apra_node_mem.sv */
// node storage: one write port, one registered read port
module apra_node_mem #(
   parameter int DEPTH  = apra_pkg::MAX_LENGTH_DEF,
   parameter int ADDR_W = $clog2(apra_pkg::MAX_LENGTH_DEF)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  apra_pkg::node_type   wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output apra_pkg::node_type   rd_data
);
   import apra_pkg::*;

   node_type mem [DEPTH];
   node_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/arith_progression_range_add.sv */
// top level: progression range add and point query over a fenwick node memory
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/stall    | operation, indices, first term, step
//   rsp_    | out       | rsp_valid/stall    | point_value, one beat per query
//   csr_    | in        | csr_valid/ready    | array_length
//
// a query walks one fenwick path, reading and summing each node;
// an add walks up to three paths (left, left+1, right+1), reading each node
// and writing back its sum, one path after another
// after reset a clearing pass zeroes every node of the memory, req_stall high
// a query result waits in the output register while the next beat is accepted
module arith_progression_range_add #(
   parameter int MAX_LENGTH = apra_pkg::MAX_LENGTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic [apra_pkg::LEN_W-1:0]   req_left_index,
   input  logic [apra_pkg::LEN_W-1:0]   req_right_index,
   input  logic signed [apra_pkg::WORD_W-1:0] req_first_term,
   input  logic signed [apra_pkg::WORD_W-1:0] req_common_step,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [apra_pkg::WORD_W-1:0] rsp_point_value,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [apra_pkg::LEN_W-1:0]   csr_array_length
);
   import apra_pkg::*;

   localparam int IW = $clog2(MAX_LENGTH + 1);
   localparam int AW = $clog2(MAX_LENGTH);
   // wide enough for indices, length and a position plus its low bit
   localparam int CW = ((IW > LEN_W) ? IW : LEN_W) + 1;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_MX   = 4'd2;
   localparam logic [3:0] S_MY   = 4'd3;
   localparam logic [3:0] S_JOB  = 4'd4;
   localparam logic [3:0] S_URD  = 4'd5;
   localparam logic [3:0] S_UWR  = 4'd6;
   localparam logic [3:0] S_QRD  = 4'd7;
   localparam logic [3:0] S_QAC  = 4'd8;
   localparam logic [3:0] S_QMUL = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   localparam logic [CW-1:0] MAX_C = CW'(MAX_LENGTH);

   logic [3:0]        state_ff, state_in;
   logic [1:0]        job_ff, job_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     x_ff, x_in;
   logic [CW-1:0]     y_ff, y_in;
   logic [WORD_W-1:0] k_ff, k_in;
   logic [WORD_W-1:0] d_ff, d_in;
   logic [WORD_W-1:0] add1_ff, add1_in;
   logic [WORD_W-1:0] add2_ff, add2_in;
   logic [WORD_W-1:0] acc1_ff, acc1_in;
   logic [WORD_W-1:0] acc2_ff, acc2_in;
   logic [WORD_W-1:0] mul_ff, mul_in;
   logic [WORD_W-1:0] prodx_ff, prodx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LEN_W-1:0]  length_ff, length_in;

   logic [CW-1:0]     len_ext, n_eff;
   logic [CW-1:0]     x_req, y_req, y_clamp, p_req;
   logic [CW-1:0]     pos_dec, pos_low;
   logic              req_fire;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
   node_type          mem_wr_data, mem_rd_data;
   logic [WORD_W-1:0] mul_a;
   logic [CW-1:0]     mul_b;

   apra_node_mem #(
      .DEPTH  (MAX_LENGTH),
      .ADDR_W (AW)
   ) u_node_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // effective length and request decode
   assign len_ext  = CW'(length_ff);
   assign n_eff    = (len_ext > MAX_C) ? MAX_C : len_ext;
   assign x_req    = CW'(req_left_index);
   assign y_req    = CW'(req_right_index);
   assign y_clamp  = (y_req > n_eff) ? n_eff : y_req;
   assign p_req    = (x_req < n_eff) ? x_req : n_eff;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // fenwick walk helpers: node address and lowest set bit
   assign pos_dec     = pos_ff - CW'(1);
   assign pos_low     = pos_ff & (-pos_ff);
   assign mem_rd_addr = pos_dec[AW-1:0];

   // one shared multiplier, operands chosen by state
   always_comb begin
      mul_a = d_ff;
      mul_b = x_ff;
      case (state_ff)
         S_MY:    mul_b = y_ff;
         S_QMUL:  mul_a = acc1_ff;
         default: mul_b = x_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      add1_in      = add1_ff;
      add2_in      = add2_ff;
      acc1_in      = acc1_ff;
      acc2_in      = acc2_ff;
      mul_in       = mul_ff;
      prodx_in     = prodx_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      length_in    = csr_valid ? csr_array_length : length_ff;

      mem_wr_en        = 1'b0;
      mem_wr_addr      = pos_dec[AW-1:0];
      mem_wr_data.slope = mem_rd_data.slope + add1_ff;
      mem_wr_data.base  = mem_rd_data.base + add2_ff;

      case (state_ff)
         S_CLR: begin
            // after reset, zero the nodes one after another up to the last, then go idle
            mem_wr_en        = 1'b1;
            mem_wr_addr      = pos_ff[AW-1:0];
            mem_wr_data.slope = '0;
            mem_wr_data.base  = '0;
            pos_in           = pos_ff + CW'(1);
            if (pos_ff == MAX_C - CW'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               k_in = req_first_term;
               d_in = req_common_step;
               if (req_operation == OP_QUERY) begin
                  x_in    = p_req;
                  pos_in  = p_req;
                  acc1_in = '0;
                  acc2_in = '0;
                  state_in = (p_req == '0) ? S_QMUL : S_QRD;
               end else begin
                  x_in = x_req;
                  y_in = y_clamp;
                  // bad add positions are dropped
                  if (x_req != '0 && x_req <= n_eff && x_req <= y_clamp) begin
                     state_in = S_MX;
                  end
               end
            end
         end
         S_MX: begin
            mul_in   = mul_a * WORD_W'(mul_b);
            state_in = S_MY;
         end
         S_MY: begin
            prodx_in = mul_ff;
            mul_in   = mul_a * WORD_W'(mul_b);
            job_in   = 2'd0;
            state_in = S_JOB;
         end
         S_JOB: begin
            // mul_ff holds step*right, prodx_ff holds step*left
            case (job_ff)
               2'd0: begin
                  // first term at left
                  pos_in   = x_ff;
                  add1_in  = '0;
                  add2_in  = k_ff;
                  job_in   = 2'd1;
                  state_in = S_URD;
               end
               2'd1: begin
                  job_in = 2'd2;
                  // step ramp starts at left+1
                  if (x_ff < y_ff) begin
                     pos_in   = x_ff + CW'(1);
                     add1_in  = d_ff;
                     add2_in  = -prodx_ff;
                     state_in = S_URD;
                  end
               end
               2'd2: begin
                  job_in = 2'd3;
                  // ramp end plus the cancelling last term at right+1
                  if (y_ff < MAX_C &&
                      (x_ff < y_ff || (y_ff + CW'(1)) <= n_eff)) begin
                     pos_in  = y_ff + CW'(1);
                     add1_in = (x_ff < y_ff) ? -d_ff : '0;
                     add2_in = ((x_ff < y_ff) ? mul_ff : '0)
                             - (((y_ff + CW'(1)) <= n_eff)
                                ? (k_ff + mul_ff - prodx_ff) : '0);
                     state_in = S_URD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_URD: begin
            state_in = S_UWR;
         end
         S_UWR: begin
            // read data arrived, write back the sum and climb
            mem_wr_en = 1'b1;
            pos_in    = pos_ff + pos_low;
            state_in  = ((pos_ff + pos_low) > MAX_C) ? S_JOB : S_URD;
         end
         S_QRD: begin
            state_in = S_QAC;
         end
         S_QAC: begin
            acc1_in  = acc1_ff + mem_rd_data.slope;
            acc2_in  = acc2_ff + mem_rd_data.base;
            pos_in   = pos_ff - pos_low;
            state_in = ((pos_ff - pos_low) == '0) ? S_QMUL : S_QRD;
         end
         S_QMUL: begin
            mul_in   = mul_a * WORD_W'(mul_b);
            state_in = S_DONE;
         end
         S_DONE: begin
            // value = position * slope sum + base sum
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_value_in = mul_ff + acc2_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         pos_ff       <= '0;
         job_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         length_ff    <= LENGTH_RESET;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
         length_ff    <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      k_ff         <= k_in;
      d_ff         <= d_in;
      add1_ff      <= add1_in;
      add2_ff      <= add2_in;
      acc1_ff      <= acc1_in;
      acc2_ff      <= acc2_in;
      mul_ff       <= mul_in;
      prodx_ff     <= prodx_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_value = rsp_value_ff;

endmodule

/* sim/apra_checker.sv */
// checker for the progression range add block: predicts point values and compares beats
`timescale 1ns / 1ps

module apra_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_operation,
   input  logic [apra_pkg::LEN_W-1:0]        req_left_index,
   input  logic [apra_pkg::LEN_W-1:0]        req_right_index,
   input  logic signed [apra_pkg::WORD_W-1:0] req_first_term,
   input  logic signed [apra_pkg::WORD_W-1:0] req_common_step,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [apra_pkg::WORD_W-1:0] rsp_point_value,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [apra_pkg::LEN_W-1:0]        csr_array_length,
   output int                                fail_count,
   output int                                values_pending
);
   import apra_pkg::*;

   localparam int DEPTH = MAX_LENGTH_DEF;

   logic [WORD_W-1:0] diff_mem [1:DEPTH];
   logic [LEN_W-1:0]  length_reg;
   logic [WORD_W-1:0] value_queue [$];

   function automatic int unsigned used_length();
      return (length_reg > DEPTH) ? DEPTH : length_reg;
   endfunction

   function automatic logic [WORD_W-1:0] point_value_at(int unsigned pos);
      logic [WORD_W-1:0] acc;
      int unsigned p;
      acc = '0;
      p = (pos < used_length()) ? pos : used_length();
      for (int unsigned i = 1; i <= p; i++) acc += diff_mem[i];
      return acc;
   endfunction

   task automatic apply_progression(int unsigned lo, int unsigned hi,
                                    logic [WORD_W-1:0] first, logic [WORD_W-1:0] step);
      int unsigned n;
      logic [WORD_W-1:0] last;
      n = used_length();
      if (hi > n) hi = n;
      if (lo == 0 || lo > n || lo > hi) return;
      diff_mem[lo] += first;
      for (int unsigned i = lo + 1; i <= hi; i++) diff_mem[i] += step;
      if (hi + 1 <= n) begin
         last = first + WORD_W'(hi - lo) * step;
         diff_mem[hi+1] -= last;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= DEPTH; i++) diff_mem[i] = '0;
         length_reg = LENGTH_RESET;
         value_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) length_reg = csr_array_length;
         if (rsp_valid && !rsp_stall) begin
            if (value_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: unexpected beat, point_value %h", rsp_point_value);
            end else begin
               logic [WORD_W-1:0] want;
               want = value_queue.pop_front();
               if (rsp_point_value !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: point_value expected %h got %h",
                              want, rsp_point_value);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_operation == OP_QUERY)
               value_queue.push_back(point_value_at(32'(req_left_index)));
            else
               apply_progression(32'(req_left_index), 32'(req_right_index),
                                 req_first_term, req_common_step);
         end
      end
      values_pending = value_queue.size();
   end

endmodule

/* sim/tb_arith_progression_range_add.sv */
// testbench top: stimulus, idling and verdict for the progression range add block
`timescale 1ns / 1ps

module tb_arith_progression_range_add;
   import apra_pkg::*;

   // drain generously past the end of the longest add
   localparam int DRAIN_CYCLES = 150;
   // clearing pass plus long stalls fit many times into this
   localparam int IDLE_LIMIT   = 20000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_operation;
   logic [LEN_W-1:0]  req_left_index;
   logic [LEN_W-1:0]  req_right_index;
   logic [WORD_W-1:0] req_first_term;
   logic [WORD_W-1:0] req_common_step;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [WORD_W-1:0] rsp_point_value;
   logic              csr_valid;
   logic              csr_ready;
   logic [LEN_W-1:0]  csr_array_length;

   int fail_count;
   int values_pending;
   bit quiet;             // no idling on either side in the last part
   int idle_cycles;
   int add_beats, query_beats, length_writes;
   int unsigned cur_length;

   arith_progression_range_add dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_operation, .req_left_index, .req_right_index,
      .req_first_term, .req_common_step,
      .rsp_valid, .rsp_stall, .rsp_point_value,
      .csr_valid, .csr_ready, .csr_array_length
   );

   apra_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_operation, .req_left_index, .req_right_index,
      .req_first_term, .req_common_step,
      .rsp_valid, .rsp_stall, .rsp_point_value,
      .csr_valid, .csr_ready, .csr_array_length,
      .fail_count, .values_pending
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver stalls in random bursts, with calm stretches between
   int stall_left;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // one request beat, maybe after a random gap; valid is only lowered for a gap
   task automatic send_beat(logic op, logic [LEN_W-1:0] lo, logic [LEN_W-1:0] hi,
                            logic [WORD_W-1:0] first, logic [WORD_W-1:0] step);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_left_index  <= lo;
      req_right_index <= hi;
      req_first_term  <= first;
      req_common_step <= step;
      do @(posedge clock); while (req_stall);
      if (op == OP_QUERY) query_beats++;
      else add_beats++;
   endtask

   // hold the sender until every expected value is back
   task automatic drain_values();
      req_valid <= 1'b0;
      @(posedge clock);
      while (values_pending != 0) @(posedge clock);
   endtask

   // length writes only when idle: all values back and the last add finished
   task automatic write_length(logic [LEN_W-1:0] len);
      drain_values();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid        <= 1'b1;
      csr_array_length <= len;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_length = (len > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : len;
      length_writes++;
   endtask

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return {1'b1, 63'd0};
         1:       return {1'b0, {63{1'b1}}};
         2:       return '1;
         3:       return WORD_W'($urandom_range(0, 20)) - 10;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly positions from 1 to one past the length, sometimes any 11-bit index
   function automatic logic [LEN_W-1:0] rand_index();
      if ($urandom_range(0, 9) == 0) return LEN_W'($urandom_range(0, 2047));
      return LEN_W'($urandom_range(1, cur_length + 1));
   endfunction

   task automatic random_beat();
      logic [LEN_W-1:0] lo, hi;
      lo = rand_index();
      hi = ($urandom_range(0, 3) == 0) ? rand_index()
                                       : LEN_W'(lo + $urandom_range(0, 40));
      if ($urandom_range(0, 9) < 4)
         send_beat(OP_QUERY, lo, hi, rand_word(), rand_word());
      else
         send_beat(OP_ADD, lo, hi, rand_word(), rand_word());
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) random_beat();
   endtask

   initial begin
      quiet = 1'b0;
      add_beats = 0; query_beats = 0; length_writes = 0;
      cur_length = LENGTH_RESET;
      reset = 1'b1;
      req_valid = 1'b0; req_operation = OP_ADD;
      req_left_index = '0; req_right_index = '0;
      req_first_term = '0; req_common_step = '0;
      csr_valid = 1'b0; csr_array_length = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: initial load as point adds, extremes, wrap, bad positions
      send_beat(OP_ADD, 11'd1, 11'd1, {1'b0, {63{1'b1}}}, 64'd5);
      send_beat(OP_ADD, 11'd1024, 11'd1024, {1'b1, 63'd0}, '1);
      send_beat(OP_ADD, 11'd2, 11'd1024, 64'd3, {1'b0, {63{1'b1}}});
      send_beat(OP_ADD, 11'd10, 11'd2047, '1, {1'b1, 63'd0});
      send_beat(OP_ADD, 11'd0, 11'd5, 64'd99, 64'd1);        // left at zero
      send_beat(OP_ADD, 11'd9, 11'd4, 64'd99, 64'd1);        // left past right
      send_beat(OP_ADD, 11'd1025, 11'd2047, 64'd7, 64'd7);   // left past length
      send_beat(OP_ADD, 11'd500, 11'd510, 64'd100, -64'sd3);
      send_beat(OP_QUERY, 11'd0, 11'd0, '0, '0);
      send_beat(OP_QUERY, 11'd1, 11'd0, '0, '0);
      send_beat(OP_QUERY, 11'd505, 11'd0, '0, '0);
      send_beat(OP_QUERY, 11'd1024, 11'd0, '0, '0);
      send_beat(OP_QUERY, 11'd2047, 11'h7ff, '1, '1);       // query past length
      drain_values();

      // a run of settings: reset length, tiny, oversized, zero, shrunk, full, partial
      random_phase(300);
      write_length(11'd1);
      send_beat(OP_ADD, 11'd1, 11'd1024, 64'd11, 64'd2);
      send_beat(OP_QUERY, 11'd1, 11'd0, '0, '0);
      random_phase(100);
      write_length(11'd2047);
      random_phase(250);
      write_length(11'd0);
      send_beat(OP_ADD, 11'd1, 11'd1, 64'd5, 64'd5);
      send_beat(OP_QUERY, 11'd3, 11'd0, '0, '0);
      random_phase(30);
      write_length(11'd37);
      random_phase(300);
      write_length(11'd1024);
      random_phase(250);
      write_length(11'd513);
      random_phase(150);
      quiet = 1'b1;
      random_phase(150);

      req_valid <= 1'b0;
      while (values_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d add beats, %0d query beats, %0d length writes",
               add_beats, query_beats, length_writes);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

/* sim.f */
design/apra_pkg.sv
design/apra_node_mem.sv
design/arith_progression_range_add.sv
sim/apra_checker.sv
sim/tb_arith_progression_range_add.sv
